// File: design/cau_pkg.sv
// package: shared types, widths, codes and saturation helper for the complex unit
package cau_pkg;

    localparam int WordBits = 32;
    localparam int FracBits = 16;
    localparam int ProdBits = 2 * WordBits + 1;
    localparam int NumBits  = ProdBits + FracBits;
    localparam int QDepth   = 2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    typedef struct packed {
        op_t                  op;
        logic signed [WordBits-1:0] a_re;
        logic signed [WordBits-1:0] a_im;
        logic signed [WordBits-1:0] b_re;
        logic signed [WordBits-1:0] b_im;
    } req_t;

    typedef struct packed {
        logic signed [WordBits-1:0] re;
        logic signed [WordBits-1:0] im;
        logic                       ovf;
    } sat_t;

    function automatic logic signed [WordBits-1:0] sat_word(
        input logic signed [NumBits-1:0] v,
        output logic                     ovf
    );
        logic signed [NumBits-1:0] hi;
        logic signed [NumBits-1:0] lo;
        hi = NumBits'({1'b0, {(WordBits-1){1'b1}}});
        lo = -hi - NumBits'(1);
        ovf = 1'b0;
        if (v > hi)
        begin
            ovf = 1'b1;
            return hi[WordBits-1:0];
        end
        else if (v < lo)
        begin
            ovf = 1'b1;
            return lo[WordBits-1:0];
        end
        return v[WordBits-1:0];
    endfunction

endpackage

// File: design/complex_arith_unit.sv
// top level: complex add, subtract, multiply and divide in signed Q16.16
// usage
//   requests enter on in_valid/in_ready with req_type and operands a, b
//   results leave on out_valid/out_ready with res_re, res_im and status
//   one request per cycle is accepted while the output side keeps up
//   every request passes the front queue, the product stage and the
//   combine stage, then the 81-stage quotient pipeline (one bit per stage)
//   or its delay line, and last the output register;
//   add, subtract and multiply ride a matching delay line so order holds
//   throughput is one request per cycle while the output side keeps up, set by the pipelined divider
//   status: 0 ok, 1 saturated, 2 divide by zero (result zero)
//   reset clears all valid flags; any request in flight is dropped, none is in flight after it
//   when the receiver stalls the whole back end holds in place and the
//   two-entry front queue absorbs requests until it fills, then in_ready
//   drops
module complex_arith_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          req_type,
    input  logic signed [cau_pkg::WordBits-1:0] a_re,
    input  logic signed [cau_pkg::WordBits-1:0] a_im,
    input  logic signed [cau_pkg::WordBits-1:0] b_re,
    input  logic signed [cau_pkg::WordBits-1:0] b_im,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cau_pkg::WordBits-1:0] res_re,
    output logic signed [cau_pkg::WordBits-1:0] res_im,
    output logic [1:0]                          status
);
    cau_pkg::req_t in_req, q_req;
    logic          q_valid, q_ready;

    always_comb
    begin
        in_req.op   = cau_pkg::op_t'(req_type);
        in_req.a_re = a_re;
        in_req.a_im = a_im;
        in_req.b_re = b_re;
        in_req.b_im = b_im;
    end

    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_req     (q_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_re    (res_re),
        .res_im    (res_im),
        .status    (status)
    );

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != 2'd3))
        else $error("bad status code");

    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == cau_pkg::ST_DIVZ) |-> (res_re == '0 && res_im == '0))
        else $error("divide by zero result not zero");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(res_re) && $stable(status)))
        else $error("stalled result changed");
endmodule

// File: design/cau_front.sv
// front end: request queue toward the arithmetic back end
module cau_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cau_pkg::req_t   in_req,
    output logic            q_valid,
    input  logic            q_ready,
    output cau_pkg::req_t   q_req
);
    localparam int PW = $clog2(cau_pkg::QDepth);

    cau_pkg::req_t       mem_reg [cau_pkg::QDepth];
    logic [PW-1:0]       wp_reg, wp_next, rp_reg, rp_next;
    logic [PW:0]         cnt_reg, cnt_next;
    logic                push, pop;

    assign in_ready = (cnt_reg != (PW+1)'(cau_pkg::QDepth));
    assign q_valid  = (cnt_reg != '0);
    assign q_req    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? wp_reg + PW'(1) : wp_reg;
        rp_next  = pop ? rp_reg + PW'(1) : rp_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_req;
        end
    end
endmodule

// File: design/cau_divider.sv
// radix-2 restoring divider, one quotient bit per stage, fully pipelined
module cau_divider (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [cau_pkg::NumBits-1:0]   num_re,
    input  logic signed [cau_pkg::NumBits-1:0]   num_im,
    input  logic        [cau_pkg::ProdBits-1:0]  den,
    output logic                                 out_valid,
    output logic signed [cau_pkg::NumBits-1:0]   q_re,
    output logic signed [cau_pkg::NumBits-1:0]   q_im
);
    localparam int NB = cau_pkg::NumBits;
    localparam int DB = cau_pkg::ProdBits;

    typedef struct packed {
        logic [NB-1:0] n_re;
        logic [NB-1:0] n_im;
        logic [DB:0]   r_re;
        logic [DB:0]   r_im;
        logic          s_re;
        logic          s_im;
        logic [DB-1:0] d;
    } dstage_t;

    dstage_t st_reg [1:NB];
    logic    v_reg  [1:NB];
    dstage_t st_next [NB];

    always_comb
    begin
        st_next[0] = '0;
        st_next[0].s_re = num_re[NB-1];
        st_next[0].s_im = num_im[NB-1];
        st_next[0].n_re = num_re[NB-1] ? NB'(-num_re) : num_re;
        st_next[0].n_im = num_im[NB-1] ? NB'(-num_im) : num_im;
        st_next[0].d    = den;
    end

    genvar g;
    generate
        for (g = 1; g < NB; g++)
        begin : g_stage
            logic [DB+1:0] tr, ti;
            always_comb
            begin
                st_next[g] = st_reg[g];
                tr = {st_reg[g].r_re, st_reg[g].n_re[NB-1]};
                ti = {st_reg[g].r_im, st_reg[g].n_im[NB-1]};
                st_next[g].n_re = {st_reg[g].n_re[NB-2:0], 1'b0};
                st_next[g].n_im = {st_reg[g].n_im[NB-2:0], 1'b0};
                if (tr >= {2'b0, st_reg[g].d})
                begin
                    tr = tr - {2'b0, st_reg[g].d};
                    st_next[g].n_re[0] = 1'b1;
                end
                if (ti >= {2'b0, st_reg[g].d})
                begin
                    ti = ti - {2'b0, st_reg[g].d};
                    st_next[g].n_im[0] = 1'b1;
                end
                st_next[g].r_re = tr[DB:0];
                st_next[g].r_im = ti[DB:0];
            end
        end
    endgenerate

    logic [DB+1:0] lr, li;
    dstage_t       last_next;
    always_comb
    begin
        last_next = st_reg[NB];
        lr = {st_reg[NB].r_re, st_reg[NB].n_re[NB-1]};
        li = {st_reg[NB].r_im, st_reg[NB].n_im[NB-1]};
        last_next.n_re = {st_reg[NB].n_re[NB-2:0], 1'b0};
        last_next.n_im = {st_reg[NB].n_im[NB-2:0], 1'b0};
        if (lr >= {2'b0, st_reg[NB].d})
        begin
            last_next.n_re[0] = 1'b1;
        end
        if (li >= {2'b0, st_reg[NB].d})
        begin
            last_next.n_im[0] = 1'b1;
        end
    end

    assign out_valid = v_reg[NB];
    assign q_re = last_next.s_re ? -$signed(last_next.n_re) : $signed(last_next.n_re);
    assign q_im = last_next.s_im ? -$signed(last_next.n_im) : $signed(last_next.n_im);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= NB; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[1] <= in_valid;
            for (int i = 2; i <= NB; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[1] <= st_next[0];
            for (int i = 2; i <= NB; i++)
            begin
                st_reg[i] <= st_next[i-1];
            end
        end
    end
endmodule

// File: design/cau_back.sv
// back end: multiply stage, divide pipeline, saturation and output register
module cau_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  cau_pkg::req_t                       q_req,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cau_pkg::WordBits-1:0] res_re,
    output logic signed [cau_pkg::WordBits-1:0] res_im,
    output logic [1:0]                          status
);
    localparam int WB = cau_pkg::WordBits;
    localparam int PB = cau_pkg::ProdBits;
    localparam int NB = cau_pkg::NumBits;
    localparam int FB = cau_pkg::FracBits;

    logic en;

    // stage 1: six products
    logic                 s1_v_reg;
    cau_pkg::req_t        s1_req_reg;
    logic signed [2*WB-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg;
    logic signed [2*WB-1:0] p_bb_reg, p_cc_reg;

    // stage 2: combined results
    logic                 s2_v_reg;
    cau_pkg::op_t         s2_op_reg;
    logic                 s2_dz_reg;
    logic signed [NB-1:0] s2_re_reg, s2_im_reg;
    logic [PB-1:0]        s2_den_reg;

    // delay line for non-divide results and the divide-by-zero flag, matching divider latency
    logic                 dl_v_reg  [1:NB];
    logic                 dl_dz_reg [1:NB];
    logic signed [NB-1:0] dl_re_reg [1:NB];
    logic signed [NB-1:0] dl_im_reg [1:NB];

    logic                 dv_out;
    logic signed [NB-1:0] dq_re, dq_im;

    logic                 o_v_reg;
    logic signed [WB-1:0] o_re_reg, o_im_reg;
    logic [1:0]           o_st_reg;

    logic                 fin_v, fin_dz, fin_div;
    logic signed [NB-1:0] fin_re, fin_im;
    cau_pkg::sat_t        sat;

    assign en = !o_v_reg || out_ready;
    assign q_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= q_valid;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_req_reg <= q_req;
            p_rr_reg <= (2*WB)'(q_req.a_re * q_req.b_re);
            p_ii_reg <= (2*WB)'(q_req.a_im * q_req.b_im);
            p_ir_reg <= (2*WB)'(q_req.a_im * q_req.b_re);
            p_ri_reg <= (2*WB)'(q_req.a_re * q_req.b_im);
            p_bb_reg <= (2*WB)'(q_req.b_re * q_req.b_re);
            p_cc_reg <= (2*WB)'(q_req.b_im * q_req.b_im);
        end
    end

    logic signed [NB-1:0] c_re, c_im;
    logic signed [PB-1:0] t_re, t_im;
    always_comb
    begin
        c_re = '0;
        c_im = '0;
        t_re = '0;
        t_im = '0;
        case (s1_req_reg.op)
            cau_pkg::OP_ADD:
            begin
                c_re = NB'(s1_req_reg.a_re) + NB'(s1_req_reg.b_re);
                c_im = NB'(s1_req_reg.a_im) + NB'(s1_req_reg.b_im);
            end
            cau_pkg::OP_SUB:
            begin
                c_re = NB'(s1_req_reg.a_re) - NB'(s1_req_reg.b_re);
                c_im = NB'(s1_req_reg.a_im) - NB'(s1_req_reg.b_im);
            end
            cau_pkg::OP_MUL:
            begin
                t_re = PB'(p_rr_reg) - PB'(p_ii_reg);
                t_im = PB'(p_ir_reg) + PB'(p_ri_reg);
                c_re = NB'(t_re >>> FB);
                c_im = NB'(t_im >>> FB);
            end
            cau_pkg::OP_DIV:
            begin
                t_re = PB'(p_rr_reg) + PB'(p_ii_reg);
                t_im = PB'(p_ir_reg) - PB'(p_ri_reg);
                c_re = NB'(t_re) <<< FB;
                c_im = NB'(t_im) <<< FB;
            end
            default:
            begin
                c_re = '0;
                c_im = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_op_reg  <= s1_req_reg.op;
            s2_re_reg  <= c_re;
            s2_im_reg  <= c_im;
            s2_den_reg <= PB'(p_bb_reg) + PB'(p_cc_reg);
            s2_dz_reg  <= (s1_req_reg.b_re == '0) && (s1_req_reg.b_im == '0);
        end
    end

    logic s2_div;
    assign s2_div = s2_v_reg && (s2_op_reg == cau_pkg::OP_DIV) && !s2_dz_reg;

    cau_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_div),
        .num_re    (s2_re_reg),
        .num_im    (s2_im_reg),
        .den       (s2_den_reg),
        .out_valid (dv_out),
        .q_re      (dq_re),
        .q_im      (dq_im)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= NB; i++)
            begin
                dl_v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            dl_v_reg[1] <= s2_v_reg;
            for (int i = 2; i <= NB; i++)
            begin
                dl_v_reg[i] <= dl_v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_re_reg[1] <= s2_re_reg;
            dl_im_reg[1] <= s2_im_reg;
            dl_dz_reg[1] <= (s2_op_reg == cau_pkg::OP_DIV) && s2_dz_reg;
            for (int i = 2; i <= NB; i++)
            begin
                dl_re_reg[i] <= dl_re_reg[i-1];
                dl_im_reg[i] <= dl_im_reg[i-1];
                dl_dz_reg[i] <= dl_dz_reg[i-1];
            end
        end
    end

    assign fin_v   = dl_v_reg[NB];
    assign fin_div = dv_out;
    assign fin_dz  = dl_dz_reg[NB];
    assign fin_re  = fin_div ? dq_re : dl_re_reg[NB];
    assign fin_im  = fin_div ? dq_im : dl_im_reg[NB];

    logic ov_re, ov_im;
    always_comb
    begin
        sat.re  = cau_pkg::sat_word(fin_re, ov_re);
        sat.im  = cau_pkg::sat_word(fin_im, ov_im);
        sat.ovf = ov_re || ov_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0;
        end
        else if (en)
        begin
            o_v_reg <= fin_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (fin_dz)
            begin
                o_re_reg <= '0;
                o_im_reg <= '0;
                o_st_reg <= cau_pkg::ST_DIVZ;
            end
            else
            begin
                o_re_reg <= sat.re;
                o_im_reg <= sat.im;
                o_st_reg <= sat.ovf ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
            end
        end
    end

    assign out_valid = o_v_reg;
    assign res_re    = o_re_reg;
    assign res_im    = o_im_reg;
    assign status    = o_st_reg;
endmodule
